// ===== hdl/smhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhs_pkg: shared types and constants of the half-step stepper mover
// Field widths, the half-step coil table, controller states, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package smhs_pkg;

   // Beat field widths
   localparam int ANGLE_W  = 10;
   localparam int RPM_W    = 4;
   localparam int COIL_W   = 4;
   localparam int PHASE_W  = 3;
   localparam int PHCNT_W  = 4;
   localparam int SEQ_W    = 11;
   localparam int PERIOD_W = 16;

   // Divider: 16-bit dividends, one quotient bit per cycle
   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = 4;
   // 0.703125 degrees per sequence: seqs = floor(angle * 64 / 45),
   // taken as floor(angle * 93207 / 2^16), exact for every 10-bit angle
   localparam int              SEQ_PROD_W      = 27;
   localparam logic [16:0]     SEQ_RECIP       = 17'd93207;
   localparam int              SEQ_RECIP_SHIFT = 16;

   localparam logic [PHASE_W-1:0] PHASE_FIRST_CW  = 3'd7;
   localparam logic [PHASE_W-1:0] PHASE_FIRST_ACW = 3'd0;
   localparam logic [PHCNT_W-1:0] PHASES_PER_SEQ = 4'd7;

   // Request function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // Direction codes
   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_ACW = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic capture;      // latch start operands, clear divider
      logic div_step;     // one restoring divide step
      logic finish_start; // commit a start, load response
      logic do_tick;      // apply one tick, load response
      logic reject;       // start while busy, load response
   } ctrl_cmd_type;

   typedef struct packed {
      logic busy;
      logic div_last;
      logic out_full;
      logic rsp_ready;
   } dpath_status_type;

   // Half-step coil pattern, bit0 IN1 .. bit3 IN4
   function automatic logic [COIL_W-1:0] half_pattern(input logic [PHASE_W-1:0] ph);
      logic [COIL_W-1:0] pat;
      case (ph)
         3'd0:    pat = 4'h1;
         3'd1:    pat = 4'h3;
         3'd2:    pat = 4'h2;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h4;
         3'd5:    pat = 4'hC;
         3'd6:    pat = 4'h8;
         3'd7:    pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

// ===== hdl/smhs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhs_if: request and response channels of the stepper mover
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface smhs_req_if import smhs_pkg::*;;
   logic               valid;
   logic               ready;
   logic               func;
   logic [ANGLE_W-1:0] angle_deg;
   logic               turn_dir;
   logic [RPM_W-1:0]   speed_rpm;

   modport source (output valid, output func, output angle_deg, output turn_dir,
                   output speed_rpm, input ready);
   modport sink   (input valid, input func, input angle_deg, input turn_dir,
                   input speed_rpm, output ready);
endinterface

interface smhs_rsp_if import smhs_pkg::*;;
   logic              valid;
   logic              ready;
   logic [COIL_W-1:0] coil_pattern;
   logic              busy_res;
   logic              move_done;
   logic              start_rejected;

   modport source (output valid, output coil_pattern, output busy_res,
                   output move_done, output start_rejected, input ready);
   modport sink   (input valid, input coil_pattern, input busy_res,
                   input move_done, input start_rejected, output ready);
endinterface

// ===== hdl/smhs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhs_ctrl: sequencing controller
// Takes request beats, runs the divider for a start, and issues the
// commands that update the motion state and load the response register.
// ----------------------------------------------------------------------------
module smhs_ctrl import smhs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   input  dpath_status_type status,
   output logic             req_ready,
   output ctrl_cmd_type     cmd
);

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // response slot must be free or draining this cycle
            req_ready = !status.out_full || status.rsp_ready;
            if (req_valid && req_ready) begin
               if (req_func == FUNC_TICK) begin
                  cmd.do_tick = 1'b1;
               end else if (status.busy) begin
                  cmd.reject = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish_start = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/smhs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhs_dpath: motion datapath
// A restoring divider for the step period, a reciprocal multiply for the
// sequence count, the phase/hold counters, the coil register and the
// response register.
// ----------------------------------------------------------------------------
module smhs_dpath import smhs_pkg::*; #(
   parameter logic [PERIOD_W-1:0] PERIOD_BASE = 16'd14648
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   input  logic [ANGLE_W-1:0] req_angle_deg,
   input  logic               req_turn_dir,
   input  logic [RPM_W-1:0]   req_speed_rpm,
   input  logic               rsp_ready,
   output dpath_status_type   status,
   output logic               rsp_valid,
   output logic [COIL_W-1:0]  rsp_coil_pattern,
   output logic               rsp_busy_res,
   output logic               rsp_move_done,
   output logic               rsp_start_rejected
);

   // Divider registers
   logic [DIV_W-1:0]     pq_ff, pq_in;     // period dividend / quotient
   logic [RPM_W-1:0]     pr_ff, pr_in;     // period remainder
   logic [RPM_W-1:0]     pd_ff, pd_in;     // rpm divisor
   logic [SEQ_W-1:0]     sq_ff, sq_in;     // sequence count of pending start
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 ndir_ff, ndir_in; // direction of pending start

   // Motion state
   logic [COIL_W-1:0]   coil_ff, coil_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [PHCNT_W-1:0]  phleft_ff, phleft_in;
   logic [SEQ_W-1:0]    seqs_ff, seqs_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] wait_ff, wait_in;
   logic                dir_ff, dir_in;
   logic                busy_ff, busy_in;

   // Response register
   logic                out_valid_ff, out_valid_in;
   logic [COIL_W-1:0]   out_coil_ff, out_coil_in;
   logic                out_busy_ff, out_busy_in;
   logic                out_done_ff, out_done_in;
   logic                out_rej_ff, out_rej_in;

   logic [RPM_W:0]       p_sh, p_diff;
   logic                 p_ge;
   logic [SEQ_PROD_W-1:0] seq_prod;
   logic                 done;
   logic [PHASE_W-1:0]   first_ph;
   logic [PHASE_W-1:0]   drive_ph;
   logic                 drive;

   // Restoring divide step for the period
   assign p_sh   = {pr_ff, pq_ff[DIV_W-1]};
   assign p_ge   = p_sh >= {1'b0, pd_ff};
   assign p_diff = p_sh - {1'b0, pd_ff};

   // Sequence count by reciprocal multiply
   assign seq_prod = SEQ_PROD_W'(req_angle_deg) * SEQ_PROD_W'(SEQ_RECIP);

   always_comb begin
      pq_in   = pq_ff;
      pr_in   = pr_ff;
      pd_in   = pd_ff;
      sq_in   = sq_ff;
      cnt_in  = cnt_ff;
      ndir_in = ndir_ff;
      if (cmd.capture) begin
         pq_in   = PERIOD_BASE;
         pr_in   = '0;
         pd_in   = (req_speed_rpm == '0) ? RPM_W'(1) : req_speed_rpm;
         sq_in   = seq_prod[SEQ_RECIP_SHIFT +: SEQ_W];
         cnt_in  = '0;
         ndir_in = req_turn_dir;
      end else if (cmd.div_step) begin
         pq_in  = {pq_ff[DIV_W-2:0], p_ge};
         pr_in  = p_ge ? p_diff[RPM_W-1:0] : p_sh[RPM_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Motion update for a committed start or a tick
   always_comb begin
      coil_in   = coil_ff;
      phase_in  = phase_ff;
      phleft_in = phleft_ff;
      seqs_in   = seqs_ff;
      period_in = period_ff;
      wait_in   = wait_ff;
      dir_in    = dir_ff;
      busy_in   = busy_ff;
      done      = 1'b0;
      drive     = 1'b0;
      drive_ph  = phase_ff;
      first_ph  = (dir_ff == DIR_ACW) ? PHASE_FIRST_ACW : PHASE_FIRST_CW;
      if (cmd.finish_start) begin
         if (sq_ff == '0) begin
            // zero-length move finishes at once
            done = 1'b1;
         end else begin
            period_in = pq_ff;
            dir_in    = ndir_ff;
            seqs_in   = sq_ff;
            phleft_in = PHASES_PER_SEQ;
            busy_in   = 1'b1;
            drive     = 1'b1;
            drive_ph  = (ndir_ff == DIR_ACW) ? PHASE_FIRST_ACW : PHASE_FIRST_CW;
         end
      end else if (cmd.do_tick && busy_ff) begin
         if (wait_ff > PERIOD_W'(1)) begin
            wait_in = wait_ff - PERIOD_W'(1);
         end else if (phleft_ff != '0) begin
            phleft_in = phleft_ff - PHCNT_W'(1);
            drive     = 1'b1;
            drive_ph  = (dir_ff == DIR_ACW) ? phase_ff + PHASE_W'(1)
                                            : phase_ff - PHASE_W'(1);
         end else if (seqs_ff > SEQ_W'(1)) begin
            seqs_in   = seqs_ff - SEQ_W'(1);
            phleft_in = PHASES_PER_SEQ;
            drive     = 1'b1;
            drive_ph  = first_ph;
         end else begin
            seqs_in = '0;
            wait_in = '0;
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
      if (drive) begin
         phase_in = drive_ph;
         coil_in  = half_pattern(drive_ph);
         wait_in  = period_in;
      end
   end

   // Response register: loaded with the state after the beat
   always_comb begin
      out_valid_in = out_valid_ff;
      out_coil_in  = out_coil_ff;
      out_busy_in  = out_busy_ff;
      out_done_in  = out_done_ff;
      out_rej_in   = out_rej_ff;
      if (cmd.finish_start || cmd.do_tick || cmd.reject) begin
         out_valid_in = 1'b1;
         out_coil_in  = coil_in;
         out_busy_in  = busy_in;
         out_done_in  = done;
         out_rej_in   = cmd.reject;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and motion registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coil_ff      <= '0;
         phase_ff     <= '0;
         phleft_ff    <= '0;
         seqs_ff      <= '0;
         period_ff    <= '0;
         wait_ff      <= '0;
         dir_ff       <= DIR_CW;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         coil_ff      <= coil_in;
         phase_ff     <= phase_in;
         phleft_ff    <= phleft_in;
         seqs_ff      <= seqs_in;
         period_ff    <= period_in;
         wait_ff      <= wait_in;
         dir_ff       <= dir_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pq_ff       <= pq_in;
      pr_ff       <= pr_in;
      pd_ff       <= pd_in;
      sq_ff       <= sq_in;
      ndir_ff     <= ndir_in;
      out_coil_ff <= out_coil_in;
      out_busy_ff <= out_busy_in;
      out_done_ff <= out_done_in;
      out_rej_ff  <= out_rej_in;
   end

   assign status.busy      = busy_ff;
   assign status.div_last  = (cnt_ff == DIV_CNT_W'(DIV_W - 1));
   assign status.out_full  = out_valid_ff;
   assign status.rsp_ready = rsp_ready;

   assign rsp_valid          = out_valid_ff;
   assign rsp_coil_pattern   = out_coil_ff;
   assign rsp_busy_res       = out_busy_ff;
   assign rsp_move_done      = out_done_ff;
   assign rsp_start_rejected = out_rej_ff;

endmodule

// ===== hdl/stepper_half_step_mover.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_half_step_mover: unipolar stepper half-step driver
// Walks the four coils through the eight-entry half-step table.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries start beats (func 0: angle, direction, rpm) and one tick
//   beat per microsecond (func 1). Every request beat yields exactly one
//   response beat on rsp_ch with the coil drive, busy, done and reject flags.
//   A tick, or a start while a move runs, needs no divide: the response
//   register loads at the accepting edge and offers the beat in the next
//   cycle, so ticks can follow back to back. A start taken while idle,
//   zero-length moves included, runs through accept, 16 steps of the
//   restoring divider for the step period, and commit; its response loads
//   at the commit and the next request is taken after that.
//   The response register decouples the sides: a new request is taken while
//   the held response is being read; if rsp_ch stalls, req_ch.ready drops
//   until the response is taken.
//   Reset (synchronous) turns all coils off, leaves the block idle and
//   empties the response register.
// ----------------------------------------------------------------------------
module stepper_half_step_mover import smhs_pkg::*; #(
   parameter int STEPS_PER_REV = 4096
) (
   input  logic        clock,
   input  logic        reset,
   smhs_req_if.sink    req_ch,
   smhs_rsp_if.source  rsp_ch
);

   // Microseconds per step at 1 rpm, held to the period width
   localparam int BaseUs  = 60000000 / STEPS_PER_REV;
   localparam int BaseSat = (BaseUs > 65535) ? 65535 : BaseUs;

   ctrl_cmd_type     cmd;
   dpath_status_type status;

   smhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .status    (status),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   smhs_dpath #(
      .PERIOD_BASE (PERIOD_W'(BaseSat))
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_angle_deg      (req_ch.angle_deg),
      .req_turn_dir       (req_ch.turn_dir),
      .req_speed_rpm      (req_ch.speed_rpm),
      .rsp_ready          (rsp_ch.ready),
      .status             (status),
      .rsp_valid          (rsp_ch.valid),
      .rsp_coil_pattern   (rsp_ch.coil_pattern),
      .rsp_busy_res       (rsp_ch.busy_res),
      .rsp_move_done      (rsp_ch.move_done),
      .rsp_start_rejected (rsp_ch.start_rejected)
   );

endmodule

// ===== hdl/smhs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhs_checker: port-level checks for the stepper mover
// Watches the response channel ports only; bound to the top level.
// ----------------------------------------------------------------------------
module smhs_checker import smhs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COIL_W-1:0] rsp_coil_pattern,
   input logic              rsp_busy_res,
   input logic              rsp_move_done,
   input logic              rsp_start_rejected
);

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coil_pattern)
         && $stable(rsp_move_done) && $stable(rsp_start_rejected))
      else $error("stalled response beat changed");

   // A finished move is no longer busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_done |-> !rsp_busy_res)
      else $error("move_done while busy");

   // A rejected start leaves the running move going
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_rejected |-> rsp_busy_res && !rsp_move_done)
      else $error("start rejected while idle");

   // Coils are driven with a table pattern, or all off before any move
   a_coil_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(rsp_coil_pattern) <= 2
         && rsp_coil_pattern != 4'h5 && rsp_coil_pattern != 4'hA)
      else $error("coil pattern outside the half-step table");

endmodule

bind stepper_half_step_mover smhs_checker u_smhs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_coil_pattern   (rsp_ch.coil_pattern),
   .rsp_busy_res       (rsp_ch.busy_res),
   .rsp_move_done      (rsp_ch.move_done),
   .rsp_start_rejected (rsp_ch.start_rejected)
);

// ===== dv/stepper_half_step_mover_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_half_step_mover_tb: self-checking bench for the half-step mover
// Feeds start and tick beats from a planned queue and predicts every
// response beat with a behavioral copy of the coil sequencer. Each response
// is checked field by field, in order. The run has three idle mixes: a
// stalling receiver, then a stalling sender, then no stalls. It also has
// one long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module stepper_half_step_mover_tb;
   import smhs_pkg::*;

   // Motor steps per revolution, as the block's default
   localparam int MOTOR_STEPS   = 4096;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int MAX_PRINTS    = 50;
   localparam int BUSY_TICKS    = 1180;

   // Half-step coil drive, phase 0 in the low nibble
   localparam logic [8*COIL_W-1:0] HALF_STEP_COILS =
      {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

   typedef struct packed {
      logic               func;
      logic [ANGLE_W-1:0] angle;
      logic               dir;
      logic [RPM_W-1:0]   rpm;
   } step_cmd_type;

   typedef struct packed {
      logic [COIL_W-1:0] coil;
      logic              busy;
      logic              done;
      logic              refused;
   } coil_status_type;

   typedef struct packed {
      logic [COIL_W-1:0]   coil;
      logic [PHASE_W-1:0]  phase;
      logic [PHCNT_W-1:0]  phases_left;
      logic [SEQ_W-1:0]    seqs_left;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] wait_cnt;
      logic                dir;
      logic                busy;
   } mover_state_type;

   typedef enum logic [1:0] {
      PACE_RX_STALLS,
      PACE_TX_STALLS,
      PACE_FREE
   } pace_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   smhs_req_if req_if ();
   smhs_rsp_if rsp_if ();

   stepper_half_step_mover #(
      .STEPS_PER_REV(MOTOR_STEPS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   step_cmd_type    step_cmd_q[$];
   coil_status_type drive_forecast_q[$];
   mover_state_type mover = '0;

   int  req_beats      = 0;
   int  rsp_beats      = 0;
   int  mode_b_at      = 32'h7fff_0000;
   int  mode_c_at      = 32'h7fff_0000;
   int  mismatch_count = 0;
   int  starts_refused = 0;
   int  empty_moves    = 0;
   int  moves_finished = 0;
   int  phase_advances = 0;
   int  hold_off_left  = 0;
   bit  hold_off_done  = 1'b0;
   bit  req_taken      = 1'b0;

   // Clock: 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int seqs_for(logic [ANGLE_W-1:0] angle);
      return (int'(angle) * 64) / 45;
   endfunction

   function automatic logic [PERIOD_W-1:0] period_for(logic [RPM_W-1:0] rpm);
      int speed;
      int per;
      speed = (rpm == 0) ? 1 : int'(rpm);
      per   = (60000000 / MOTOR_STEPS) / speed;
      if (per > 16'hFFFF) per = 16'hFFFF;
      return per[PERIOD_W-1:0];
   endfunction

   function automatic void energize(logic [PHASE_W-1:0] ph);
      mover.phase    = ph;
      mover.coil     = HALF_STEP_COILS[ph*COIL_W +: COIL_W];
      mover.wait_cnt = mover.period;
   endfunction

   // One request beat in, the coil status it leaves behind out
   function automatic coil_status_type advance_mover(step_cmd_type cmd);
      coil_status_type st;
      int              seqs;
      st   = '0;
      seqs = seqs_for(cmd.angle);
      if (cmd.func == FUNC_START) begin
         if (mover.busy) begin
            st.refused = 1'b1;
            starts_refused++;
         end else if (seqs == 0) begin
            st.done = 1'b1;
            empty_moves++;
         end else begin
            mover.period      = period_for(cmd.rpm);
            mover.dir         = cmd.dir;
            mover.seqs_left   = seqs[SEQ_W-1:0];
            mover.phases_left = PHASES_PER_SEQ;
            mover.busy        = 1'b1;
            energize(mover.dir == DIR_ACW ? PHASE_FIRST_ACW : PHASE_FIRST_CW);
         end
      end else if (mover.busy) begin
         if (mover.wait_cnt > 1) begin
            mover.wait_cnt--;
         end else if (mover.phases_left != 0) begin
            mover.phases_left--;
            energize(mover.dir == DIR_ACW ? mover.phase + 3'd1 : mover.phase - 3'd1);
            phase_advances++;
         end else if (mover.seqs_left > 1) begin
            // next sequence restarts from the first phase of the direction
            mover.seqs_left--;
            mover.phases_left = PHASES_PER_SEQ;
            energize(mover.dir == DIR_ACW ? PHASE_FIRST_ACW : PHASE_FIRST_CW);
         end else begin
            // last phase held out: coils keep their pattern
            mover.seqs_left = '0;
            mover.wait_cnt  = '0;
            mover.busy      = 1'b0;
            st.done         = 1'b1;
            moves_finished++;
         end
      end
      st.coil = mover.coil;
      st.busy = mover.busy;
      return st;
   endfunction

   // ---------------------------------------------------------------- planning
   task automatic plan_start(int angle, logic dir, int rpm);
      step_cmd_type cmd;
      cmd.func  = FUNC_START;
      cmd.angle = angle[ANGLE_W-1:0];
      cmd.dir   = dir;
      cmd.rpm   = rpm[RPM_W-1:0];
      step_cmd_q.push_back(cmd);
   endtask

   task automatic plan_tick();
      step_cmd_type cmd;
      cmd       = '0;
      cmd.func  = FUNC_TICK;
      cmd.angle = $urandom_range(1023);
      cmd.dir   = $urandom_range(1);
      cmd.rpm   = $urandom_range(15);
      step_cmd_q.push_back(cmd);
   endtask

   // Idle noise: ticks with nothing to do and zero-length starts
   task automatic plan_chatter(int n);
      repeat (n) begin
         if ($urandom_range(1)) plan_tick();
         else plan_start(0, $urandom_range(1), $urandom_range(15));
      end
   endtask

   // Ticks into a running move, with refused starts sprinkled in and one
   // on the tick just before each phase advance
   task automatic plan_busy_ticks(int n, int rpm);
      int per;
      per = int'(period_for(rpm[RPM_W-1:0]));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(39) == 0 || (i % per == per - 1))
            plan_start($urandom_range(1023), $urandom_range(1), $urandom_range(15));
         plan_tick();
      end
   endtask

   // ---------------------------------------------------------------- pacing
   function automatic pace_type pace_now();
      if (req_beats < mode_b_at) return PACE_RX_STALLS;
      if (req_beats < mode_c_at) return PACE_TX_STALLS;
      return PACE_FREE;
   endfunction

   function automatic int idle_pct(bit rx_side);
      case (pace_now())
         PACE_RX_STALLS: return rx_side ? 88 : 10;
         PACE_TX_STALLS: return rx_side ? 10 : 88;
         default:        return 0;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic log_mismatch(string msg);
      if (mismatch_count < MAX_PRINTS)
         $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want)
         log_mismatch($sformatf("rsp beat %0d %s got %h want %h", rsp_beats, name, got, want));
   endtask

   // Request driver: presents queued beats at the falling edge
   always @(negedge clock) begin : req_driver
      step_cmd_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (step_cmd_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
            nxt = step_cmd_q.pop_front();
            req_if.func      <= nxt.func;
            req_if.angle_deg <= nxt.angle;
            req_if.turn_dir  <= nxt.dir;
            req_if.speed_rpm <= nxt.rpm;
            req_if.valid     <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls plus the long hold-off
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= (hold_off_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
   end

   // Long receiver hold-off, once, inside the stall-free stretch
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_off_done && req_beats >= mode_c_at + 300) begin
            hold_off_left = HOLD_OFF_LEN;
            hold_off_done = 1'b1;
         end else if (hold_off_left != 0) begin
            hold_off_left--;
         end
      end
   end

   // Monitor: predict on each request beat, check each response beat
   always @(posedge clock) begin : beat_monitor
      step_cmd_type    cmd;
      coil_status_type got;
      coil_status_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            cmd.func  = req_if.func;
            cmd.angle = req_if.angle_deg;
            cmd.dir   = req_if.turn_dir;
            cmd.rpm   = req_if.speed_rpm;
            drive_forecast_q.push_back(advance_mover(cmd));
            req_beats <= req_beats + 1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.coil    = rsp_if.coil_pattern;
            got.busy    = rsp_if.busy_res;
            got.done    = rsp_if.move_done;
            got.refused = rsp_if.start_rejected;
            if (drive_forecast_q.size() == 0) begin
               log_mismatch($sformatf("response beat %h with nothing pending", got));
            end else begin
               want = drive_forecast_q.pop_front();
               check_field("coil_pattern", got.coil, want.coil);
               check_field("busy_res", got.busy, want.busy);
               check_field("move_done", got.done, want.done);
               check_field("start_rejected", got.refused, want.refused);
            end
            rsp_beats++;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      req_if.valid     = 1'b0;
      req_if.func      = FUNC_TICK;
      req_if.angle_deg = '0;
      req_if.turn_dir  = DIR_CW;
      req_if.speed_rpm = '0;
      rsp_if.ready     = 1'b0;

      // Directed: idle tick, zero-length starts at both speed extremes
      plan_tick();
      plan_start(0, DIR_ACW, 15);
      plan_start(0, DIR_CW, 0);
      plan_start(0, DIR_ACW, 15);
      plan_chatter(30);

      // Widest angle at top speed: first phase held, then one phase advance,
      // with starts refused throughout
      plan_start(1023, DIR_CW, 15);
      plan_busy_ticks(BUSY_TICKS, 15);
      plan_start(341, DIR_ACW, 10);

      // Split the run into the three idle mixes
      mode_b_at = step_cmd_q.size() / 3;
      mode_c_at = (2 * step_cmd_q.size()) / 3;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
         #1;
      end while (step_cmd_q.size() != 0 || req_if.valid || drive_forecast_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request beats: %0d moves finished, %0d phase advances,",
               req_beats, moves_finished, phase_advances);
      $display("  %0d starts refused while busy, %0d zero-length starts, %0d mismatches",
               starts_refused, empty_moves, mismatch_count);
      if (mismatch_count == 0) begin
         $display("stepper_half_step_mover test passed");
      end else begin
         $display("stepper_half_step_mover test failed");
      end
      $finish;
   end

   // Watchdog: far above the slowest expected run
   initial begin
      #1_000_000;
      $display("timeout: %0d beats queued, %0d responses pending",
               step_cmd_q.size(), drive_forecast_q.size());
      $display("stepper_half_step_mover test failed");
      $finish;
   end

endmodule
